// ===== sv/bse_pkg.sv =====
`timescale 1ns / 1ps

package bse_pkg;

    // number formats
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int ITER_BITS  = 10;
    localparam int WORD_W     = 32;
    localparam int STEP_W     = 31;
    localparam int GRAY_W     = 8;

    // derived widths
    localparam int PROD_W  = 2 * WORD_W;
    localparam int SQ_W    = PROD_W - FRAC_BITS;
    localparam int CROSS_W = PROD_W - FRAC_BITS + 1;
    localparam int MAP_W   = COORD_BITS + STEP_W;
    localparam int WIDE_W  = ((MAP_W > CROSS_W) ? MAP_W : CROSS_W) + 2;
    localparam int NUM_W   = ITER_BITS + GRAY_W;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // stream words
    localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = ITER_BITS + 1 + GRAY_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int INSIDE_BIT = ITER_BITS;
    localparam int GRAY_LSB   = ITER_BITS + 1;

    // register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_MAX_ITER   = 2'd0;
    localparam logic [1:0] REG_RE_START   = 2'd1;
    localparam logic [1:0] REG_IM_START   = 2'd2;
    localparam logic [1:0] REG_PIXEL_STEP = 2'd3;

    localparam logic [ITER_BITS-1:0] MAX_ITER_RST   = ITER_BITS'(390);
    localparam logic [WORD_W-1:0]    RE_START_RST   = WORD_W'(-590558003);
    localparam logic [WORD_W-1:0]    IM_START_RST   = WORD_W'(-483183821);
    localparam logic [STEP_W-1:0]    PIXEL_STEP_RST = STEP_W'(1073742);

    // escape threshold: |z|^2 >= 4.0
    localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(1) << (FRAC_BITS + 2);

    localparam logic signed [WIDE_W-1:0] WIDE_WMAX =
        {{(WIDE_W - WORD_W + 1){1'b0}}, {(WORD_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_WMIN =
        {{(WIDE_W - WORD_W + 1){1'b1}}, {(WORD_W - 1){1'b0}}};

    typedef struct packed {
        logic [ITER_BITS-1:0]     max_iter;
        logic signed [WORD_W-1:0] re_start;
        logic signed [WORD_W-1:0] im_start;
        logic [STEP_W-1:0]        pixel_step;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic map;
        logic seed;
        logic mul;
        logic step;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic escape;
        logic at_limit;
        logic div_done;
    } status_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WIDE_WMAX)
        begin
            r = WIDE_WMAX[WORD_W-1:0];
        end
        else if (v < WIDE_WMIN)
        begin
            r = WIDE_WMIN[WORD_W-1:0];
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/burning_ship_escape_time.sv =====
`timescale 1ns / 1ps
// Flow: an input word is mapped and seeded, then the multiply and test states alternate
// until the point escapes or reaches the limit; an escaped point then runs the divider.
// Throughput: one pixel at a time; the next word is taken the cycle after the result
// loads, and the result loads only once the output register is free.
// Reset: rst_n is asynchronous, active low; it idles the controller, clears the output
// valid and loads the default view and an iteration limit of 390.
module burning_ship_escape_time
    import bse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // pix_x, pix_y
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // iter_count, inside_set, gray_level, pad
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    bse_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bse_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

// ===== sv/bse_regs.sv =====
`timescale 1ns / 1ps

module bse_regs
    import bse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [ITER_BITS-1:0] max_iter_reg;
    logic [WORD_W-1:0]    re_start_reg;
    logic [WORD_W-1:0]    im_start_reg;
    logic [STEP_W-1:0]    pixel_step_reg;
    logic                 wr_en;
    logic [1:0]           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg   <= MAX_ITER_RST;
            re_start_reg   <= RE_START_RST;
            im_start_reg   <= IM_START_RST;
            pixel_step_reg <= PIXEL_STEP_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_MAX_ITER:   max_iter_reg   <= pwdata[ITER_BITS-1:0];
                REG_RE_START:   re_start_reg   <= pwdata[WORD_W-1:0];
                REG_IM_START:   im_start_reg   <= pwdata[WORD_W-1:0];
                REG_PIXEL_STEP: pixel_step_reg <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MAX_ITER:   prdata = APB_DATA_W'(max_iter_reg);
            REG_RE_START:   prdata = APB_DATA_W'(re_start_reg);
            REG_IM_START:   prdata = APB_DATA_W'(im_start_reg);
            REG_PIXEL_STEP: prdata = APB_DATA_W'(pixel_step_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.max_iter   = max_iter_reg;
    assign cfg.re_start   = re_start_reg;
    assign cfg.im_start   = im_start_reg;
    assign cfg.pixel_step = pixel_step_reg;

endmodule

// ===== sv/bse_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bse_div
    import bse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     numer,
    input  logic [ITER_BITS-1:0] denom,
    output logic                 done,
    output logic [NUM_W-1:0]     quot
);

    logic [NUM_W-1:0]     num_reg;
    logic [ITER_BITS-1:0] den_reg;
    logic [ITER_BITS-1:0] rem_reg;
    logic [NUM_W-1:0]     quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [ITER_BITS:0]   rem_shift;
    logic [ITER_BITS+1:0] diff;
    logic                 q_bit;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign q_bit     = ~diff[ITER_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= numer;
            den_reg  <= denom;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= q_bit ? diff[ITER_BITS-1:0] : rem_shift[ITER_BITS-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], q_bit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== sv/bse_datapath.sv =====
`timescale 1ns / 1ps

module bse_datapath
    import bse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [COORD_BITS-1:0]    px_reg;
    logic [COORD_BITS-1:0]    py_reg;
    logic [MAP_W-1:0]         prod_x_reg;
    logic [MAP_W-1:0]         prod_y_reg;
    logic signed [WORD_W-1:0] cr_reg;
    logic signed [WORD_W-1:0] ci_reg;
    logic signed [WORD_W-1:0] zr_reg;
    logic signed [WORD_W-1:0] zi_reg;
    logic [PROD_W-1:0]        aa_reg;
    logic [PROD_W-1:0]        bb_reg;
    logic [PROD_W-1:0]        ab_reg;
    logic [ITER_BITS-1:0]     count_reg;
    logic [ITER_BITS-1:0]     out_count_reg;
    logic                     out_inside_reg;
    logic [GRAY_W-1:0]        out_gray_reg;

    logic [WORD_W-1:0]        mag_r;
    logic [WORD_W-1:0]        mag_i;
    logic [SQ_W-1:0]          rr;
    logic [SQ_W-1:0]          ii;
    logic [CROSS_W-1:0]       ri;
    logic signed [WIDE_W-1:0] cr_ext;
    logic signed [WIDE_W-1:0] ci_ext;
    logic signed [WIDE_W-1:0] re_map_sum;
    logic signed [WIDE_W-1:0] im_map_sum;
    logic signed [WIDE_W-1:0] zr_sum;
    logic signed [WIDE_W-1:0] zi_sum;
    logic [NUM_W-1:0]         gray_numer;
    logic [NUM_W-1:0]         quot;
    logic                     div_done;

    assign mag_r = zr_reg[WORD_W-1] ? (~zr_reg + 1'b1) : zr_reg;
    assign mag_i = zi_reg[WORD_W-1] ? (~zi_reg + 1'b1) : zi_reg;

    assign rr = aa_reg[PROD_W-1:FRAC_BITS];
    assign ii = bb_reg[PROD_W-1:FRAC_BITS];
    assign ri = ab_reg[PROD_W-1:FRAC_BITS-1];

    assign re_map_sum = {{(WIDE_W - WORD_W){cfg.re_start[WORD_W-1]}}, cfg.re_start}
                      + {{(WIDE_W - MAP_W){1'b0}}, prod_x_reg};
    assign im_map_sum = {{(WIDE_W - WORD_W){cfg.im_start[WORD_W-1]}}, cfg.im_start}
                      + {{(WIDE_W - MAP_W){1'b0}}, prod_y_reg};

    assign cr_ext = {{(WIDE_W - WORD_W){cr_reg[WORD_W-1]}}, cr_reg};
    assign ci_ext = {{(WIDE_W - WORD_W){ci_reg[WORD_W-1]}}, ci_reg};
    assign zr_sum = {{(WIDE_W - SQ_W){1'b0}}, rr} - {{(WIDE_W - SQ_W){1'b0}}, ii} + cr_ext;
    assign zi_sum = {{(WIDE_W - CROSS_W){1'b0}}, ri} + ci_ext;

    assign status.escape   = ({1'b0, rr} + {1'b0, ii}) >= ESC_LIMIT;
    assign status.at_limit = count_reg >= cfg.max_iter;
    assign status.div_done = div_done;

    // count * 255 as (count << 8) - count
    assign gray_numer = {count_reg, {GRAY_W{1'b0}}} - NUM_W'(count_reg);

    bse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (gray_numer),
        .denom (cfg.max_iter),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= s_tdata[COORD_BITS-1:0];
            py_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
        if (cmd.map)
        begin
            prod_x_reg <= MAP_W'(px_reg) * MAP_W'(cfg.pixel_step);
            prod_y_reg <= MAP_W'(py_reg) * MAP_W'(cfg.pixel_step);
        end
        if (cmd.seed)
        begin
            cr_reg    <= sat_word(re_map_sum);
            ci_reg    <= sat_word(im_map_sum);
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            zr_reg    <= sat_word(zr_sum);
            zi_reg    <= sat_word(zi_sum);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.mul)
        begin
            aa_reg <= PROD_W'(mag_r) * PROD_W'(mag_r);
            bb_reg <= PROD_W'(mag_i) * PROD_W'(mag_i);
            ab_reg <= PROD_W'(mag_r) * PROD_W'(mag_i);
        end
        if (cmd.out_load)
        begin
            out_count_reg  <= count_reg;
            out_inside_reg <= status.at_limit;
            out_gray_reg   <= status.at_limit ? '0 : quot[GRAY_W-1:0];
        end
    end

    assign m_tdata = M_TDATA_W'({out_gray_reg, out_inside_reg, out_count_reg});

endmodule

// ===== sv/bse_ctrl.sv =====
`timescale 1ns / 1ps

module bse_ctrl
    import bse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_SEED = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_TEST = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = ~out_valid_reg | m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (status.at_limit)
                begin
                    state_next = ST_OUT;
                end
                else if (status.escape)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== sv/bse_checker.sv =====
`timescale 1ns / 1ps

module bse_checker
    import bse_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  psel,
    input logic                  pready
);

    logic [GRAY_W-1:0] gray;
    logic              in_set;

    assign gray   = m_tdata[GRAY_LSB+GRAY_W-1:GRAY_LSB];
    assign in_set = m_tdata[INSIDE_BIT];

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one pixel in flight: no second word taken right after the first
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && in_set |-> gray == '0)
        else $error("inside point with nonzero gray level");

    // escaped points have count < limit, so the scaled level stays below full scale
    a_escaped_gray: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !in_set |-> gray != {GRAY_W{1'b1}})
        else $error("escaped point at full-scale gray level");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("register port stalled");

endmodule

bind burning_ship_escape_time bse_checker u_bse_checker (.*);

// ===== tb/tb_burning_ship_escape_time.sv =====
`timescale 1ns / 1ps

module tb_burning_ship_escape_time;
    import bse_pkg::*;

    typedef struct packed {
        logic [ITER_BITS-1:0] iter_count;
        logic                 inside_set;
        logic [GRAY_W-1:0]    gray_level;
    } escape_t;

    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -WORD_HI - 1;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // pix_x, pix_y
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // iter_count, inside_set, gray_level, pad
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow copy of the register file
    logic [ITER_BITS-1:0]     cfg_max_iter   = MAX_ITER_RST;
    logic signed [WORD_W-1:0] cfg_re_start   = RE_START_RST;
    logic signed [WORD_W-1:0] cfg_im_start   = IM_START_RST;
    logic [STEP_W-1:0]        cfg_pixel_step = PIXEL_STEP_RST;

    escape_t expected_escapes[$];
    int      error_count   = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_len      = 0;
    logic    recv_holding  = 1'b0;
    event    hold_kick;

    burning_ship_escape_time dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit log_slot();
        error_count++;
        return error_count <= 10;
    endfunction

    function automatic longint clamp_word(input longint v);
        if (v > WORD_HI)
        begin
            return WORD_HI;
        end
        if (v < WORD_LO)
        begin
            return WORD_LO;
        end
        return v;
    endfunction

    function automatic escape_t predict_escape(input logic [COORD_BITS-1:0] px,
                                               input logic [COORD_BITS-1:0] py);
        longint          cr, ci, zr, zi;
        longint unsigned a, b, rr, ii, ri;
        int unsigned     n;
        escape_t         r;
        cr = clamp_word(longint'(cfg_re_start) + longint'(px) * longint'(cfg_pixel_step));
        ci = clamp_word(longint'(cfg_im_start) + longint'(py) * longint'(cfg_pixel_step));
        zr = 0;
        zi = 0;
        n  = 0;
        while (1)
        begin
            a  = (zr < 0) ? -zr : zr;
            b  = (zi < 0) ? -zi : zi;
            rr = (a * a) >> FRAC_BITS;
            ii = (b * b) >> FRAC_BITS;
            if (rr + ii >= (64'd4 << FRAC_BITS) || n >= cfg_max_iter)
            begin
                break;
            end
            // cross term 2ab folded into the shift
            ri = (a * b) >> (FRAC_BITS - 1);
            zr = clamp_word(longint'(rr) - longint'(ii) + cr);
            zi = clamp_word(longint'(ri) + ci);
            n++;
        end
        r.iter_count = ITER_BITS'(n);
        r.inside_set = (n >= cfg_max_iter);
        r.gray_level = r.inside_set ? '0 : GRAY_W'((n * 255) / cfg_max_iter);
        return r;
    endfunction

    function automatic void check_escape(input logic [M_TDATA_W-1:0] word);
        escape_t want, got;
        got.iter_count = word[ITER_BITS-1:0];
        got.inside_set = word[INSIDE_BIT];
        got.gray_level = word[GRAY_LSB +: GRAY_W];
        if (expected_escapes.size() == 0)
        begin
            if (log_slot())
            begin
                $display("unexpected result word %h", word);
            end
            return;
        end
        want = expected_escapes.pop_front();
        if (got.iter_count !== want.iter_count || got.inside_set !== want.inside_set ||
            got.gray_level !== want.gray_level)
        begin
            if (log_slot())
            begin
                $display("result mismatch: want count=%0d inside=%0d gray=%0d",
                         want.iter_count, want.inside_set, want.gray_level);
                $display("                 got  count=%0d inside=%0d gray=%0d",
                         got.iter_count, got.inside_set, got.gray_level);
            end
        end
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_image(input logic [1:0] idx);
        case (idx)
            REG_MAX_ITER: return APB_DATA_W'(cfg_max_iter);
            REG_RE_START: return cfg_re_start;
            REG_IM_START: return cfg_im_start;
            default:      return APB_DATA_W'(cfg_pixel_step);
        endcase
    endfunction

    // receiver: checks accepted words, stalls at random or during a long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_escape(m_tdata);
            end
            m_tready <= !recv_holding && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(hold_kick);
            recv_holding <= 1'b1;
            repeat (hold_len) @(posedge clk);
            recv_holding <= 1'b0;
        end
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic verify_reg(input logic [1:0] idx);
        logic [APB_DATA_W-1:0] got;
        apb_access(1'b0, idx, '0, got);
        if (got !== reg_image(idx))
        begin
            if (log_slot())
            begin
                $display("register %0d readback: want %h got %h", idx, reg_image(idx), got);
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] discard;
        apb_access(1'b1, idx, value, discard);
        case (idx)
            REG_MAX_ITER: cfg_max_iter   = value[ITER_BITS-1:0];
            REG_RE_START: cfg_re_start   = value;
            REG_IM_START: cfg_im_start   = value;
            default:      cfg_pixel_step = value[STEP_W-1:0];
        endcase
        verify_reg(idx);
    endtask

    task automatic set_view(input logic [31:0] iters, input logic [31:0] re0,
                            input logic [31:0] im0, input logic [31:0] step);
        cfg_write(REG_MAX_ITER, iters);
        cfg_write(REG_RE_START, re0);
        cfg_write(REG_IM_START, im0);
        cfg_write(REG_PIXEL_STEP, step);
    endtask

    // random window over the ship region, short iteration limit
    task automatic ship_view(input int unsigned iter_cap);
        set_view(32'($urandom_range(1, iter_cap)),
                 32'(-671088640 + int'($urandom_range(0, 402653184))),
                 32'(-536870912 + int'($urandom_range(0, 402653184))),
                 32'($urandom_range(40000, 260000)));
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({py, px});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_escapes.push_back(predict_escape(px, py));
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_pixel(COORD_BITS'($urandom_range(4095)), COORD_BITS'($urandom_range(4095)));
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_escapes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_view();
        verify_reg(REG_MAX_ITER);
        verify_reg(REG_RE_START);
        verify_reg(REG_IM_START);
        verify_reg(REG_PIXEL_STEP);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);   // both coordinates saturate
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd550, 12'd450);     // c near zero, stays inside
        send_pixel(12'd112, 12'd442);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        settle();
    endtask

    task automatic test_register_extremes();
        // zero limit: no iteration, no divide
        set_view(32'd0, RE_START_RST, IM_START_RST, 32'(PIXEL_STEP_RST));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd550, 12'd450);
        settle();
        cfg_write(REG_MAX_ITER, 32'd1);
        send_pixel(12'd550, 12'd450);
        send_pixel(12'd4095, 12'd4095);
        settle();
        cfg_write(REG_MAX_ITER, 32'd2);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd550, 12'd450);
        settle();
        set_view(32'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        settle();
        set_view(32'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_pixel(12'd1, 12'd2);
        settle();
    endtask

    task automatic test_full_limit();
        set_view(32'd1023, 32'd0, 32'd0, 32'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        settle();
        set_view(32'd1023, 32'(-469762048), 32'(-8053064), 32'd262144);
        send_random_pixels(4);
        settle();
    endtask

    task automatic test_random_views(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            settle();
            if ($urandom_range(3) == 0)
            begin
                // arbitrary register words; upper bits above each field must be dropped
                set_view(($urandom & 32'hFFFF_FC00) | $urandom_range(0, 63),
                         $urandom, $urandom, $urandom);
            end
            else
            begin
                ship_view(48);
            end
            send_random_pixels(per_phase);
        end
        settle();
    endtask

    task automatic test_backpressure();
        ship_view(8);
        hold_len = 400;
        -> hold_kick;
        send_random_pixels(16);
        // hold input until every word is back, then resume
        settle();
        send_random_pixels(8);
        settle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 65;
        test_reset_view();
        test_register_extremes();
        test_full_limit();
        test_random_views(10, 44);

        send_idle_pct = 65;
        recv_idle_pct = 30;
        test_random_views(10, 44);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_views(10, 44);
        test_backpressure();

        repeat (2 * 1023 + 40) @(posedge clk);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bse_pkg.sv
sv/bse_regs.sv
sv/bse_div.sv
sv/bse_datapath.sv
sv/bse_ctrl.sv
sv/burning_ship_escape_time.sv
sv/bse_checker.sv
tb/tb_burning_ship_escape_time.sv
